// File: rtl/ils_pkg.sv
package ils_pkg;

  localparam int N_UNK = 3;
  localparam int IDX_W = 2;
  localparam int FRAC_BITS = 32;
  localparam int MAT_DEPTH = N_UNK * N_UNK;
  localparam int MAT_W = 4;

  localparam logic [1:0] ACT_LOAD_COEFF = 2'd0;
  localparam logic [1:0] ACT_LOAD_RHS   = 2'd1;
  localparam logic [1:0] ACT_SOLVE      = 2'd2;

  localparam logic [1:0] CFG_METHOD    = 2'd0;
  localparam logic [1:0] CFG_TOLERANCE = 2'd1;
  localparam logic [1:0] CFG_MAX_ITER  = 2'd2;

  localparam logic [1:0] ST_CONVERGED = 2'd0;
  localparam logic [1:0] ST_LIMIT     = 2'd1;
  localparam logic [1:0] ST_ZERO_DIAG = 2'd2;

  localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             clear;      // zero solution, count and change
    logic             chk_diag;   // test diagonal entry of row
    logic             iter_start; // zero the running maximum
    logic             acc_init;   // accumulator takes the rhs
    logic             mul_start;  // register product operands for column
    logic             acc_sub;    // subtract the registered product
    logic             div_start;  // start the serial divider
    logic             row_commit; // store new value and update maximum
    logic             iter_end;   // count iteration, copy Jacobi vector
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } ils_cmd_t;

  // Status from the datapath.
  typedef struct packed {
    logic zero_diag;
    logic mul_done;
    logic div_done;
    logic above;
    logic limit_hit;
  } ils_stat_t;

  function automatic logic [63:0] mag64(input logic [63:0] v);
    mag64 = v[63] ? (64'd0 - v) : v;
  endfunction

  function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    r = a - b;
    if (((a ^ b) & (a ^ r)) >> 63 != 64'd0) sat_sub = a[63] ? S64_MIN : S64_MAX;
    else sat_sub = r;
  endfunction

  function automatic logic [63:0] signed_sat(input logic neg, input logic big,
                                             input logic [63:0] m);
    logic [63:0] lim;
    logic [63:0] mm;
    lim = neg ? S64_MIN : S64_MAX;
    mm = (big || m > lim) ? lim : m;
    signed_sat = neg ? (64'd0 - mm) : mm;
  endfunction

endpackage

// File: rtl/ils_ctrl.sv
module ils_ctrl
  import ils_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  ils_stat_t        stat,
  input  logic             out_free,
  output ils_cmd_t         cmd,
  output logic             busy,
  output logic             emit,
  output logic [IDX_W-1:0] emit_idx
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_DIAG  = 10'b0000000010,
    S_TEST  = 10'b0000000100,
    S_ROW   = 10'b0000001000,
    S_MUL   = 10'b0000010000,
    S_SUB   = 10'b0000100000,
    S_DIV   = 10'b0001000000,
    S_WAIT  = 10'b0010000000,
    S_NEXT  = 10'b0100000000,
    S_EMIT  = 10'b1000000000
  } state_t;

  state_t state, state_next;
  logic [IDX_W-1:0] row, row_next, col, col_next;

  assign busy = (state != S_IDLE);
  assign emit_idx = row;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      row <= '0;
      col <= '0;
    end else begin
      state <= state_next;
      row <= row_next;
      col <= col_next;
    end
  end

  // Sequencing of rows, columns and iterations.
  always_comb begin
    state_next = state;
    row_next = row;
    col_next = col;
    cmd = '0;
    cmd.row = row;
    cmd.col = col;
    emit = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.clear = 1'b1;
          row_next = '0;
          state_next = S_DIAG;
        end
      end
      S_DIAG: begin
        cmd.chk_diag = 1'b1;
        if (row == IDX_W'(N_UNK - 1)) begin
          row_next = '0;
          state_next = S_TEST;
        end else begin
          row_next = row + 1'b1;
        end
      end
      S_TEST: begin
        row_next = '0;
        if (stat.zero_diag || stat.limit_hit || !stat.above) begin
          state_next = S_EMIT;
        end else begin
          cmd.iter_start = 1'b1;
          state_next = S_ROW;
        end
      end
      S_ROW: begin
        cmd.acc_init = 1'b1;
        col_next = '0;
        state_next = S_MUL;
      end
      S_MUL: begin
        if (col == row) begin
          if (col == IDX_W'(N_UNK - 1)) state_next = S_DIV;
          else col_next = col + 1'b1;
        end else begin
          cmd.mul_start = 1'b1;
          state_next = S_SUB;
        end
      end
      S_SUB: begin
        if (stat.mul_done) begin
          cmd.acc_sub = 1'b1;
          if (col == IDX_W'(N_UNK - 1)) begin
            state_next = S_DIV;
          end else begin
            col_next = col + 1'b1;
            state_next = S_MUL;
          end
        end
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (stat.div_done) begin
          cmd.row_commit = 1'b1;
          state_next = S_NEXT;
        end
      end
      S_NEXT: begin
        if (row == IDX_W'(N_UNK - 1)) begin
          cmd.iter_end = 1'b1;
          row_next = '0;
          state_next = S_TEST;
        end else begin
          row_next = row + 1'b1;
          state_next = S_ROW;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          emit = 1'b1;
          if (row == IDX_W'(N_UNK - 1)) begin
            row_next = '0;
            state_next = S_IDLE;
          end else begin
            row_next = row + 1'b1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: rtl/ils_div.sv
module ils_div
  import ils_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        done,
  output logic [63:0] quot
);

  localparam int NB = 64 + FRAC_BITS;
  localparam int CW = 7;

  logic [NB-1:0] dividend;
  logic [NB-1:0] q;
  logic [64:0]   rem;
  logic [63:0]   dm;
  logic          neg;
  logic          run;
  logic          fin;
  logic [CW-1:0] cnt;
  logic [64:0]   shifted;
  logic [64:0]   diff;

  // One quotient bit per cycle, restoring form.
  assign shifted = {rem[63:0], dividend[NB-1]};
  assign diff = shifted - {1'b0, dm};

  // Run and finish flags; the saturated quotient is registered from the finish flag, alongside done.
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      fin <= 1'b0;
      done <= 1'b0;
    end else begin
      fin <= run && !start && (cnt == '0);
      done <= fin;
      if (start) run <= 1'b1;
      else if (run && cnt == '0) run <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= CW'(NB - 1);
      dividend <= {mag64(num), {FRAC_BITS{1'b0}}};
      dm <= mag64(den);
      neg <= num[63] ^ den[63];
      rem <= '0;
      q <= '0;
    end else if (run) begin
      dividend <= dividend << 1;
      if (!diff[64]) begin
        rem <= diff;
        q <= {q[NB-2:0], 1'b1};
      end else begin
        rem <= shifted;
        q <= {q[NB-2:0], 1'b0};
      end
      if (cnt != '0) cnt <= cnt - 1'b1;
    end
    if (fin) quot <= signed_sat(neg, q[NB-1:64] != '0, q[63:0]);
  end

endmodule

// File: rtl/ils_dpath.sv
module ils_dpath
  import ils_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             load_coeff,
  input  logic             load_rhs,
  input  logic [IDX_W-1:0] ld_row,
  input  logic [IDX_W-1:0] ld_col,
  input  logic [63:0]      ld_value,
  input  logic             method,
  input  logic [31:0]      tolerance,
  input  logic [7:0]       max_iterations,
  input  ils_cmd_t         cmd,
  output ils_stat_t        stat,
  input  logic [IDX_W-1:0] rd_idx,
  output logic [63:0]      rd_solution,
  output logic [7:0]       iter_count,
  output logic [62:0]      final_change,
  output logic [1:0]       status
);

  logic [63:0] coeff [MAT_DEPTH];
  logic [63:0] rhs [N_UNK];
  logic [63:0] sol [N_UNK];
  logic [63:0] nxt [N_UNK];
  logic [63:0] acc;
  logic [63:0] max_chg;
  logic        zdiag;
  logic        above;
  logic [63:0] mul_a, mul_b;
  logic        mul_neg;
  logic [1:0]   mul_step;
  logic         mul_run;
  logic         mul_fin;
  logic         mul_done;
  logic [31:0]  pa, pb;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [127:0] prod;
  logic [63:0]  prod_sat;
  logic         div_done;
  logic [63:0]  quot;
  logic [63:0]  chg;

  function automatic logic [MAT_W-1:0] midx(input logic [IDX_W-1:0] r,
                                            input logic [IDX_W-1:0] c);
    midx = MAT_W'(r * N_UNK + c);
  endfunction

  // Coefficient and rhs storage.
  always_ff @(posedge clk) begin
    if (load_coeff) coeff[midx(ld_row, ld_col)] <= ld_value;
    if (load_rhs) rhs[ld_row] <= ld_value;
  end

  // One 32x32 partial product per cycle, low halves first.
  assign pa = mul_step[1] ? mul_a[63:32] : mul_a[31:0];
  assign pb = mul_step[0] ? mul_b[63:32] : mul_b[31:0];
  assign pp = {32'd0, pa} * {32'd0, pb};

  always_comb begin
    case (mul_step)
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
  end

  // Multiplier sequencing: four accumulate steps, then one saturation step.
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_run <= 1'b0;
      mul_fin <= 1'b0;
      mul_done <= 1'b0;
      mul_step <= '0;
    end else begin
      mul_fin <= mul_run && (mul_step == 2'd3);
      mul_done <= mul_fin;
      if (cmd.mul_start) begin
        mul_run <= 1'b1;
        mul_step <= '0;
      end else if (mul_run) begin
        mul_step <= mul_step + 1'b1;
        if (mul_step == 2'd3) mul_run <= 1'b0;
      end
    end
  end

  // Product of magnitudes, accumulated over the partial products.
  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      mul_a <= mag64(coeff[midx(cmd.row, cmd.col)]);
      mul_b <= mag64(sol[cmd.col]);
      mul_neg <= coeff[midx(cmd.row, cmd.col)][63] ^ sol[cmd.col][63];
      prod <= '0;
    end else if (mul_run) begin
      prod <= prod + pp_sh;
    end
    if (mul_fin) begin
      prod_sat <= signed_sat(mul_neg, prod[127:64+FRAC_BITS] != '0,
                             prod[63+FRAC_BITS:FRAC_BITS]);
    end
  end

  ils_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.div_start),
    .num  (acc),
    .den  (coeff[midx(cmd.row, cmd.row)]),
    .done (div_done),
    .quot (quot)
  );

  logic [63:0] cdiff;
  assign cdiff = mag64(sat_sub(quot, sol[cmd.row]));
  assign chg = cdiff[63] ? S64_MAX : cdiff;

  always_ff @(posedge clk) begin
    if (rst) begin
      zdiag <= 1'b0;
      above <= 1'b1;
      iter_count <= '0;
      max_chg <= '0;
      for (int i = 0; i < N_UNK; i++) begin
        sol[i] <= '0;
        nxt[i] <= '0;
      end
    end else begin
      if (cmd.clear) begin
        zdiag <= 1'b0;
        above <= 1'b1;
        iter_count <= '0;
        max_chg <= '0;
        for (int i = 0; i < N_UNK; i++) begin
          sol[i] <= '0;
          nxt[i] <= '0;
        end
      end
      if (cmd.chk_diag && coeff[midx(cmd.row, cmd.row)] == '0) zdiag <= 1'b1;
      if (cmd.iter_start) max_chg <= '0;
      if (cmd.acc_init) acc <= rhs[cmd.row];
      if (cmd.acc_sub) acc <= sat_sub(acc, prod_sat);
      if (cmd.row_commit) begin
        if (chg > max_chg) max_chg <= chg;
        if (method) nxt[cmd.row] <= quot;
        else sol[cmd.row] <= quot;
      end
      if (cmd.iter_end) begin
        iter_count <= iter_count + 1'b1;
        above <= max_chg > {32'd0, tolerance};
        if (method) begin
          for (int i = 0; i < N_UNK; i++) sol[i] <= nxt[i];
        end
      end
    end
  end

  assign stat.zero_diag = zdiag;
  assign stat.mul_done = mul_done;
  assign stat.div_done = div_done;
  assign stat.above = above;
  assign stat.limit_hit = (iter_count >= max_iterations);

  assign rd_solution = sol[rd_idx];
  assign final_change = max_chg[62:0];
  assign status = zdiag ? ST_ZERO_DIAG : (above ? ST_LIMIT : ST_CONVERGED);

endmodule

// File: rtl/iterative_linear_solver.sv
// A solve runs k iterations with N = 3: each row forms its off-diagonal products, runs the
// 96-bit serial divider and its sequencing, and a test of the change and the limit comes
// before each iteration. Results then leave one per cycle when the receiver is ready.
// One item is worked at a time; input and configuration wait until the last word issues.
// Reset (synchronous, active high) restores register defaults and clears the solution.
module iterative_linear_solver
  import ils_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         action,
  input  logic [1:0]         row,
  input  logic [1:0]         col,
  input  logic signed [63:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         unknown_index,
  output logic signed [63:0] solution,
  output logic [7:0]         iterations_used,
  output logic [62:0]        final_change,
  output logic [1:0]         status,
  output logic               last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  logic        method;
  logic [31:0] tolerance;
  logic [7:0]  max_iterations;
  ils_cmd_t    cmd;
  ils_stat_t   stat;
  logic        busy, emit, in_acc, out_free;
  logic [IDX_W-1:0] emit_idx;
  logic [63:0] rd_sol;
  logic [7:0]  it_cnt;
  logic [62:0] fchg;
  logic [1:0]  st;

  assign cfg_ready = !busy;
  assign in_ready = !busy;
  assign in_acc = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      method <= 1'b0;
      tolerance <= 32'd42950;
      max_iterations <= 8'd20;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_METHOD:    method <= cfg_data[0];
        CFG_TOLERANCE: tolerance <= cfg_data;
        CFG_MAX_ITER:  max_iterations <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  ils_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (in_acc && action == ACT_SOLVE),
    .stat    (stat),
    .out_free(out_free),
    .cmd     (cmd),
    .busy    (busy),
    .emit    (emit),
    .emit_idx(emit_idx)
  );

  ils_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .load_coeff    (in_acc && action == ACT_LOAD_COEFF && row < IDX_W'(N_UNK)
                    && col < IDX_W'(N_UNK)),
    .load_rhs      (in_acc && action == ACT_LOAD_RHS && row < IDX_W'(N_UNK)),
    .ld_row        (row),
    .ld_col        (col),
    .ld_value      (value),
    .method        (method),
    .tolerance     (tolerance),
    .max_iterations(max_iterations),
    .cmd           (cmd),
    .stat          (stat),
    .rd_idx        (emit_idx),
    .rd_solution   (rd_sol),
    .iter_count    (it_cnt),
    .final_change  (fchg),
    .status        (st)
  );

  // Output word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      unknown_index <= emit_idx;
      solution <= rd_sol;
      iterations_used <= it_cnt;
      final_change <= fchg;
      status <= st;
      last <= (emit_idx == IDX_W'(N_UNK - 1));
    end
  end

  // No input is taken while a solve is in progress.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !in_ready) else $error("input taken during solve");

  // A word is only issued into a free output register.
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    emit |-> (!out_valid || out_ready)) else $error("output word overwritten");

  // A zero-diagonal result reports no iterations.
  a_zd_iter: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_ZERO_DIAG) |-> iterations_used == 8'd0)
    else $error("iterations on zero diagonal");

endmodule

// File: tb/tb_iterative_linear_solver.sv
`timescale 1ns / 100ps

module tb_iterative_linear_solver;
  import ils_pkg::*;

  localparam int  CYCLE_LIMIT = 4000000;
  localparam int  HOLD_CYCLES = 400;
  localparam logic [1:0] ACT_IGNORED = 2'd3;
  localparam logic [1:0] IDX_OUT = 2'd3;
  localparam logic [63:0] Q_ONE = 64'h0000_0001_0000_0000;

  typedef struct packed {
    logic [1:0]  idx;
    logic [63:0] sol;
    logic [7:0]  iters;
    logic [62:0] chg;
    logic [1:0]  st;
    logic        fin;
  } unknown_word_t;

  typedef struct packed {
    logic [1:0]  act;
    logic [1:0]  r;
    logic [1:0]  c;
    logic [63:0] v;
    logic        typed_zero_diag;
  } stim_row_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         action;
  logic [1:0]         row;
  logic [1:0]         col;
  logic signed [63:0] value;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         unknown_index;
  logic signed [63:0] solution;
  logic [7:0]         iterations_used;
  logic [62:0]        final_change;
  logic [1:0]         status;
  logic               last;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [31:0]        cfg_data;

  // Predictor state: loaded system and register copies.
  logic [63:0] coeff_mem [N_UNK*N_UNK];
  logic [63:0] rhs_mem [N_UNK];
  logic        solve_jacobi;
  logic [31:0] tol_reg;
  logic [7:0]  iter_limit;

  unknown_word_t expected_unknowns[$];
  int   mismatches;
  int   items_sent;
  int   cycles;
  bit   calm;
  bit   hold_req;

  iterative_linear_solver dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Fixed point helpers, Q32.32 with saturation.
  function automatic logic [63:0] abs_q(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  function automatic logic [63:0] clamp_q(input bit neg, input bit big,
                                          input logic [63:0] m);
    logic [63:0] lim;
    lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    if (big || m > lim) m = lim;
    return neg ? (64'd0 - m) : m;
  endfunction

  function automatic logic [63:0] diff_q(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    r = a - b;
    if (a[63] != b[63] && r[63] != a[63])
      return a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    return r;
  endfunction

  function automatic logic [63:0] mul_q(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, abs_q(a)} * {64'd0, abs_q(b)};
    return clamp_q(a[63] ^ b[63], p[127:96] != 0, p[95:32]);
  endfunction

  function automatic logic [63:0] div_q(input logic [63:0] n, input logic [63:0] d);
    logic [127:0] q;
    q = {32'd0, abs_q(n), 32'd0} / {64'd0, abs_q(d)};
    return clamp_q(n[63] ^ d[63], q[127:64] != 0, q[63:0]);
  endfunction

  // Runs one solve on the predictor and queues the three unknown words.
  task automatic predict_solve();
    logic [63:0] x [N_UNK];
    logic [63:0] xn [N_UNK];
    logic [63:0] acc, nv, ch, worst;
    logic [1:0]  st;
    int          n;
    bit          above, zdiag;
    unknown_word_t w;
    worst = 0;
    n = 0;
    above = 1;
    zdiag = 0;
    for (int i = 0; i < N_UNK; i++) begin
      x[i] = 0;
      xn[i] = 0;
      if (coeff_mem[i*N_UNK+i] == 0) zdiag = 1;
    end
    if (zdiag) begin
      st = ST_ZERO_DIAG;
    end else begin
      while (above && n < iter_limit) begin
        worst = 0;
        for (int i = 0; i < N_UNK; i++) begin
          acc = rhs_mem[i];
          for (int j = 0; j < N_UNK; j++)
            if (j != i) acc = diff_q(acc, mul_q(coeff_mem[i*N_UNK+j], x[j]));
          nv = div_q(acc, coeff_mem[i*N_UNK+i]);
          ch = abs_q(diff_q(nv, x[i]));
          if (ch > 64'h7FFF_FFFF_FFFF_FFFF) ch = 64'h7FFF_FFFF_FFFF_FFFF;
          if (ch > worst) worst = ch;
          if (solve_jacobi) xn[i] = nv;
          else x[i] = nv;
        end
        if (solve_jacobi) x = xn;
        n++;
        above = worst > {32'd0, tol_reg};
      end
      st = above ? ST_LIMIT : ST_CONVERGED;
    end
    for (int i = 0; i < N_UNK; i++) begin
      w.idx = i[1:0];
      w.sol = x[i];
      w.iters = n[7:0];
      w.chg = worst[62:0];
      w.st = st;
      w.fin = (i == N_UNK - 1);
      expected_unknowns.push_back(w);
    end
  endtask

  // Applies one accepted input word to the predictor.
  task automatic absorb_item(input stim_row_t s);
    unknown_word_t w;
    if (s.act == ACT_LOAD_COEFF) begin
      if (s.r < N_UNK && s.c < N_UNK) coeff_mem[s.r*N_UNK+s.c] = s.v;
    end else if (s.act == ACT_LOAD_RHS) begin
      if (s.r < N_UNK) rhs_mem[s.r] = s.v;
    end else if (s.act == ACT_SOLVE) begin
      if (s.typed_zero_diag) begin
        for (int i = 0; i < N_UNK; i++) begin
          w = '0;
          w.idx = i[1:0];
          w.st = ST_ZERO_DIAG;
          w.fin = (i == N_UNK - 1);
          expected_unknowns.push_back(w);
        end
      end else begin
        predict_solve();
      end
    end
  endtask

  // Offers one word and waits for it to be taken. Entered at a falling edge.
  task automatic send_item(input stim_row_t s);
    if (!calm && $urandom_range(0, 99) < 33) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    action = s.act;
    row = s.r;
    col = s.c;
    value = s.v;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    absorb_item(s);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send(input logic [1:0] a, input logic [1:0] r, input logic [1:0] c,
                      input logic [63:0] v);
    send_item('{a, r, c, v, 1'b0});
  endtask

  // Waits until the block is idle, then writes one register.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    in_valid = 1'b0;
    while (expected_unknowns.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
    cfg_index = idx;
    cfg_data = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_METHOD) solve_jacobi = data[0];
    else if (idx == CFG_TOLERANCE) tol_reg = data;
    else if (idx == CFG_MAX_ITER) iter_limit = data[7:0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_mode(input logic m, input logic [31:0] tol, input logic [7:0] lim);
    write_reg(CFG_METHOD, {$urandom} & 32'hFFFF_FFFE | {31'd0, m});
    write_reg(CFG_TOLERANCE, tol);
    write_reg(CFG_MAX_ITER, {$urandom} & 32'hFFFF_FF00 | {24'd0, lim});
  endtask

  function automatic logic [63:0] dominant_diag();
    logic [63:0] m;
    m = {$urandom_range(6, 40), $urandom};
    return $urandom_range(0, 1) ? (64'd0 - m) : m;
  endfunction

  function automatic logic [63:0] small_coeff(input int span);
    logic [63:0] m;
    m = {$urandom_range(0, span), $urandom};
    return $urandom_range(0, 1) ? (64'd0 - m) : m;
  endfunction

  // One random load sequence ending in a solve.
  task automatic run_group(input bit well_formed);
    int kind;
    logic [1:0] rr, cc;
    kind = well_formed ? 0 : $urandom_range(0, 9);
    if (kind <= 6) begin
      for (int r = 0; r < N_UNK; r++) begin
        for (int c = 0; c < N_UNK; c++)
          send(ACT_LOAD_COEFF, r[1:0], c[1:0], (r == c) ? dominant_diag() : small_coeff(2));
        send(ACT_LOAD_RHS, r[1:0], 2'($urandom), small_coeff(1000));
      end
    end else if (kind == 7) begin
      repeat ($urandom_range(2, 6))
        send(2'($urandom_range(0, 1)), 2'($urandom), 2'($urandom), {$urandom, $urandom});
      send(ACT_IGNORED, 2'($urandom), 2'($urandom), {$urandom, $urandom});
    end else if (kind == 8) begin
      send(ACT_LOAD_COEFF, 2'($urandom_range(0, 2)), 2'($urandom_range(0, 2)), 64'd0);
      send(ACT_LOAD_COEFF, IDX_OUT, 2'($urandom), {$urandom, $urandom});
      send(ACT_LOAD_RHS, IDX_OUT, 2'($urandom), {$urandom, $urandom});
    end else begin
      repeat ($urandom_range(3, 8)) begin
        rr = 2'($urandom_range(0, 2));
        cc = 2'($urandom_range(0, 2));
        if ($urandom_range(0, 2) == 0) send(ACT_LOAD_RHS, rr, cc, small_coeff(500));
        else send(ACT_LOAD_COEFF, rr, cc, (rr == cc) ? dominant_diag() : small_coeff(3));
      end
    end
    send(ACT_SOLVE, 2'($urandom), 2'($urandom), {$urandom, $urandom});
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at cycle %0d: %s got %h expected %h", cycles, what, got, want);
    mismatches++;
  endtask

  // Result checker.
  always @(posedge clk) begin
    unknown_word_t w;
    if (!rst && out_valid && out_ready) begin
      if (expected_unknowns.size() == 0) begin
        report_mismatch("unexpected word, index", 64'(unknown_index), 64'd0);
      end else begin
        w = expected_unknowns.pop_front();
        if (unknown_index !== w.idx) report_mismatch("unknown_index", 64'(unknown_index), 64'(w.idx));
        if (solution !== w.sol) report_mismatch("solution", solution, w.sol);
        if (iterations_used !== w.iters)
          report_mismatch("iterations_used", 64'(iterations_used), 64'(w.iters));
        if (final_change !== w.chg) report_mismatch("final_change", 64'(final_change), 64'(w.chg));
        if (status !== w.st) report_mismatch("status", 64'(status), 64'(w.st));
        if (last !== w.fin) report_mismatch("last", 64'(last), 64'(w.fin));
      end
    end
  end

  // Cycle budget.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_iterative_linear_solver: FAIL");
      $finish;
    end
  end

  // Receiver: random back-pressure, with one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ready = calm || ($urandom_range(0, 99) >= 33);
    end
  end

  // Directed table: loads, extremes, ignored words and a zero diagonal.
  stim_row_t directed [] = '{
    '{ACT_LOAD_COEFF, 2'd0, 2'd0, 64'h0000_0004_0000_0000, 1'b0},
    '{ACT_LOAD_COEFF, 2'd0, 2'd1, 64'hFFFF_FFFF_0000_0000, 1'b0},
    '{ACT_LOAD_COEFF, 2'd0, 2'd2, 64'h0000_0000_8000_0000, 1'b0},
    '{ACT_LOAD_COEFF, 2'd1, 2'd0, 64'h0000_0001_0000_0000, 1'b0},
    '{ACT_LOAD_COEFF, 2'd1, 2'd1, 64'h0000_0005_0000_0000, 1'b0},
    '{ACT_LOAD_COEFF, 2'd1, 2'd2, 64'h0000_0001_0000_0000, 1'b0},
    '{ACT_LOAD_COEFF, 2'd2, 2'd0, 64'h0000_0000_4000_0000, 1'b0},
    '{ACT_LOAD_COEFF, 2'd2, 2'd1, 64'hFFFF_FFFE_0000_0000, 1'b0},
    '{ACT_LOAD_COEFF, 2'd2, 2'd2, 64'hFFFF_FFFA_0000_0000, 1'b0},
    '{ACT_LOAD_RHS,   2'd0, 2'd0, 64'h0000_0014_0000_0000, 1'b0},
    '{ACT_LOAD_RHS,   2'd1, 2'd0, 64'hFFFF_FF9C_0000_0000, 1'b0},
    '{ACT_LOAD_RHS,   2'd2, 2'd0, 64'h0000_0032_0000_0000, 1'b0},
    '{ACT_SOLVE,      2'd0, 2'd0, 64'd0, 1'b0},
    // Out-of-range loads and the unused action leave everything alone.
    '{ACT_LOAD_COEFF, 2'd3, 2'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0},
    '{ACT_LOAD_COEFF, 2'd0, 2'd3, 64'd0, 1'b0},
    '{ACT_LOAD_RHS,   2'd3, 2'd3, 64'd0, 1'b0},
    '{ACT_IGNORED,    2'd3, 2'd3, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0},
    // Saturating extremes off the diagonal and in the right-hand side.
    '{ACT_LOAD_COEFF, 2'd0, 2'd1, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0},
    '{ACT_LOAD_RHS,   2'd1, 2'd2, 64'h8000_0000_0000_0000, 1'b0},
    '{ACT_SOLVE,      2'd3, 2'd3, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0},
    // A zero on the diagonal gives all zeros.
    '{ACT_LOAD_COEFF, 2'd1, 2'd1, 64'd0, 1'b0},
    '{ACT_SOLVE,      2'd0, 2'd0, 64'd0, 1'b1},
    '{ACT_LOAD_COEFF, 2'd1, 2'd1, 64'h8000_0000_0000_0000, 1'b0},
    '{ACT_LOAD_RHS,   2'd0, 2'd0, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0},
    '{ACT_SOLVE,      2'd0, 2'd0, 64'd0, 1'b0}
  };

  // Main sequence.
  initial begin
    int target;
    rst = 1'b1;
    in_valid = 1'b0;
    action = ACT_LOAD_COEFF;
    row = '0;
    col = '0;
    value = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_METHOD;
    cfg_data = '0;
    solve_jacobi = 1'b0;
    tol_reg = 32'd42950;
    iter_limit = 8'd20;
    mismatches = 0;
    items_sent = 0;
    cycles = 0;
    calm = 1'b0;
    hold_req = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed[k]) send_item(directed[k]);

    // Gauss-Seidel at the default setting.
    target = items_sent + 15;
    while (items_sent < target) run_group(1'b0);

    // Jacobi with no idling on either side.
    set_mode(1'b1, 32'd42950, 8'd20);
    calm = 1'b1;
    target = items_sent + 10;
    while (items_sent < target) run_group(1'b0);
    calm = 1'b0;

    // Zero tolerance at the largest limit, one well-formed system.
    set_mode(1'b1, 32'd0, 8'd255);
    run_group(1'b1);

    // Widest tolerance, with a long receiver hold-off.
    set_mode(1'b0, 32'hFFFF_FFFF, 8'd8);
    hold_req = 1'b1;
    target = items_sent + 10;
    while (items_sent < target) run_group(1'b0);

    // Random settings.
    set_mode(1'($urandom), $urandom, 8'($urandom_range(1, 30)));
    target = items_sent + 15;
    while (items_sent < target) run_group(1'b0);

    // A zero limit runs no iteration.
    set_mode(1'b0, 32'd0, 8'd0);
    run_group(1'b1);

    set_mode(1'b0, 32'd42950, 8'd1);
    target = items_sent + 10;
    while (items_sent < target) run_group(1'b0);

    in_valid = 1'b0;
    while (expected_unknowns.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_iterative_linear_solver: PASS");
    end else begin
      $display("tb_iterative_linear_solver: FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/ils_pkg.sv
rtl/ils_ctrl.sv
rtl/ils_div.sv
rtl/ils_dpath.sv
rtl/iterative_linear_solver.sv
tb/tb_iterative_linear_solver.sv
